/* rtl/crrm_pkg.sv */
// Types and constants for the chained range-remap block with running minimum.
// No dependencies; used by chained_range_remap_min_top.
package crrm_pkg;

  localparam int unsigned VAL_W       = 64;
  localparam int unsigned IN_TDATA_W  = 272;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 128;

  // Input tdata field offsets, lowest bit up.
  localparam int unsigned STG_LSB  = 0;
  localparam int unsigned STG_W    = 3;
  localparam int unsigned IDX_LSB  = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned EVLD_LSB = 9;
  localparam int unsigned DEST_LSB = 10;
  localparam int unsigned SRC_LSB  = 74;
  localparam int unsigned LEN_LSB  = 138;
  localparam int unsigned VIN_LSB  = 202;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_XLATE = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] dest;
    logic [VAL_W-1:0] src;
    logic [VAL_W-1:0] len;
  } entry_t;

endpackage

/* rtl/chained_range_remap_min_top.sv */
// Chained range-remap tables with a running minimum of translated values.
// Depends on crrm_pkg (field offsets, function codes, states, entry type).
//
// Channel | Dir | Handshake                    | Payload
// s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser: func; tdata: entry write or value
// m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: mapped_value, min_value
//
// A write or clear item is handled in the idle state, which stays ready for the next
// item. A translate item scans the entries of every stage through one table read port
// and one subtract/compare unit, one entry a cycle while it scans; a hit at entry k ends
// that stage's scan, and the value is remapped before the next stage starts. After reset
// a clearing pass over all NUM_STAGES*ENTRIES_PER_STAGE entries zeroes the valid bits;
// no item is taken meanwhile. The result sits in an output register, so the next item
// is taken while it waits; a translate finishing into a full output register stalls.
module chained_range_remap_min_top #(
  parameter int NUM_STAGES        = 7,
  parameter int ENTRIES_PER_STAGE = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // stage_sel[2:0], entry_index[8:3], entry_valid[9], dest_start[73:10],
  // src_start[137:74], range_len[201:138], value_in[265:202], zero pad
  input  logic [crrm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // func[1:0]
  input  logic [crrm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // mapped_value[63:0], min_value[127:64]
  output logic [crrm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int TOTAL = NUM_STAGES * ENTRIES_PER_STAGE;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int EW    = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
  localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int VW    = crrm_pkg::VAL_W;

  crrm_pkg::state_e state_q, state_d;

  // Input field views
  crrm_pkg::func_e                 in_func;
  logic [crrm_pkg::STG_W-1:0]      in_stg;
  logic [crrm_pkg::IDX_W-1:0]      in_idx;
  logic [VW-1:0]                   in_val;
  logic                            in_acc;
  logic                            in_range;
  logic [AW-1:0]                   in_addr;
  crrm_pkg::entry_t                in_entry;

  assign in_func  = crrm_pkg::func_e'(s_axis_tuser);
  assign in_stg   = s_axis_tdata[crrm_pkg::STG_LSB +: crrm_pkg::STG_W];
  assign in_idx   = s_axis_tdata[crrm_pkg::IDX_LSB +: crrm_pkg::IDX_W];
  assign in_val   = s_axis_tdata[crrm_pkg::VIN_LSB +: VW];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = (32'(in_stg) < 32'(NUM_STAGES)) && (32'(in_idx) < 32'(ENTRIES_PER_STAGE));
  assign in_addr  = AW'(32'(in_stg) * 32'(ENTRIES_PER_STAGE) + 32'(in_idx));

  assign in_entry.vld  = s_axis_tdata[crrm_pkg::EVLD_LSB];
  assign in_entry.dest = s_axis_tdata[crrm_pkg::DEST_LSB +: VW];
  assign in_entry.src  = s_axis_tdata[crrm_pkg::SRC_LSB +: VW];
  assign in_entry.len  = s_axis_tdata[crrm_pkg::LEN_LSB +: VW];

  // Table memory
  crrm_pkg::entry_t mem [TOTAL];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  crrm_pkg::entry_t mem_wdata;
  logic             rd_en;
  crrm_pkg::entry_t rd_q;

  // Sequencer registers
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [VW-1:0] v_q, v_d;
  logic [AW-1:0] iss_addr_q, iss_addr_d;
  logic [EW-1:0] iss_ent_q, iss_ent_d;
  logic [SW-1:0] iss_stg_q, iss_stg_d;
  logic          iss_on_q, iss_on_d;
  logic          rvld_q, rvld_d;
  logic [AW-1:0] raddr_q;
  logic [EW-1:0] rent_q;
  logic [SW-1:0] rstg_q;
  logic          meta_ld;
  logic [VW-1:0] diff_q, dest_q;
  logic [VW-1:0] min_q, min_d;
  logic          m_valid_q, m_valid_d;
  logic [VW-1:0] m_map_q, m_min_q;
  logic          out_ld;

  // Shared compare unit
  logic [VW:0]   sub;
  logic [VW-1:0] diff;
  logic          hit;
  logic          rlast_ent, rlast_stg;
  logic [VW-1:0] new_min;
  logic          clr_acc;

  assign sub       = {1'b0, v_q} - {1'b0, rd_q.src};
  assign diff      = sub[VW-1:0];
  assign hit       = rvld_q && rd_q.vld && !sub[VW] && (diff < rd_q.len);
  assign rlast_ent = (rent_q == EW'(ENTRIES_PER_STAGE - 1));
  assign rlast_stg = (rstg_q == SW'(NUM_STAGES - 1));
  assign new_min   = (v_q < min_q) ? v_q : min_q;
  assign clr_acc   = in_acc && (in_func == crrm_pkg::FUNC_CLEAR);

  assign s_axis_tready = (state_q == crrm_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_min_q, m_map_q};

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    v_d        = v_q;
    iss_addr_d = iss_addr_q;
    iss_ent_d  = iss_ent_q;
    iss_stg_d  = iss_stg_q;
    iss_on_d   = iss_on_q;
    rvld_d     = 1'b0;
    rd_en      = 1'b0;
    meta_ld    = 1'b0;
    min_d      = min_q;
    out_ld     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = in_addr;
    mem_wdata  = in_entry;
    m_valid_d  = m_valid_q && !m_axis_tready;

    unique case (state_q)
      crrm_pkg::ST_CLR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr_q;
        mem_wdata.vld = 1'b0;
        if (clr_addr_q == AW'(TOTAL - 1)) begin
          state_d = crrm_pkg::ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end

      crrm_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            crrm_pkg::FUNC_WRITE: mem_we = in_range;
            crrm_pkg::FUNC_XLATE: begin
              v_d        = in_val;
              iss_addr_d = '0;
              iss_ent_d  = '0;
              iss_stg_d  = '0;
              iss_on_d   = 1'b1;
              state_d    = crrm_pkg::ST_SCAN;
            end
            crrm_pkg::FUNC_CLEAR: min_d = '1;
            default: ;
          endcase
        end
      end

      crrm_pkg::ST_SCAN: begin
        // Issue the next read while the previous one is compared.
        if (iss_on_q) begin
          rd_en      = 1'b1;
          rvld_d     = 1'b1;
          meta_ld    = !hit;
          iss_addr_d = iss_addr_q + AW'(1);
          if (iss_ent_q == EW'(ENTRIES_PER_STAGE - 1)) begin
            iss_ent_d = '0;
            if (iss_stg_q == SW'(NUM_STAGES - 1)) begin
              iss_on_d = 1'b0;
            end else begin
              iss_stg_d = iss_stg_q + SW'(1);
            end
          end else begin
            iss_ent_d = iss_ent_q + EW'(1);
          end
        end
        if (hit) begin
          // Drop the read in flight; the value changes before it is used.
          rvld_d   = 1'b0;
          iss_on_d = 1'b0;
          state_d  = crrm_pkg::ST_APPLY;
        end else if (rvld_q && rlast_ent && rlast_stg) begin
          state_d = crrm_pkg::ST_FINISH;
        end
      end

      crrm_pkg::ST_APPLY: begin
        v_d = dest_q + diff_q;
        if (rlast_stg) begin
          state_d = crrm_pkg::ST_FINISH;
        end else begin
          iss_addr_d = AW'(32'(raddr_q) + 32'(ENTRIES_PER_STAGE) - 32'(rent_q));
          iss_ent_d  = '0;
          iss_stg_d  = rstg_q + SW'(1);
          iss_on_d   = 1'b1;
          state_d    = crrm_pkg::ST_SCAN;
        end
      end

      crrm_pkg::ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          out_ld    = 1'b1;
          m_valid_d = 1'b1;
          min_d     = new_min;
          state_d   = crrm_pkg::ST_IDLE;
        end
      end

      default: state_d = crrm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= crrm_pkg::ST_CLR;
      clr_addr_q <= '0;
      iss_addr_q <= '0;
      iss_ent_q  <= '0;
      iss_stg_q  <= '0;
      iss_on_q   <= 1'b0;
      rvld_q     <= 1'b0;
      raddr_q    <= '0;
      rent_q     <= '0;
      rstg_q     <= '0;
      min_q      <= '1;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      iss_addr_q <= iss_addr_d;
      iss_ent_q  <= iss_ent_d;
      iss_stg_q  <= iss_stg_d;
      iss_on_q   <= iss_on_d;
      rvld_q     <= rvld_d;
      min_q      <= min_d;
      m_valid_q  <= m_valid_d;
      if (meta_ld) begin
        raddr_q <= iss_addr_q;
        rent_q  <= iss_ent_q;
        rstg_q  <= iss_stg_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (hit) begin
      diff_q <= diff;
      dest_q <= rd_q.dest;
    end
    if (out_ld) begin
      m_map_q <= v_q;
      m_min_q <= new_min;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[iss_addr_q];
    end
  end

  a_min_rises_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (min_q > $past(min_q)) |-> $past(clr_acc))
    else $error("running minimum grew without a clear item");

  a_result_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_min_q <= m_map_q))
    else $error("reported minimum exceeds mapped value");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crrm_pkg::ST_SCAN || state_q == crrm_pkg::ST_APPLY) |-> !mem_we)
    else $error("table written during a translation");

  a_apply_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crrm_pkg::ST_APPLY) |-> $past(hit))
    else $error("remap applied without a matching entry");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == crrm_pkg::ST_FINISH))
    else $error("result loaded outside the finish step");

endmodule

/* dv/chained_range_remap_min_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for chained_range_remap_min_top: entry writes, clears and
// translations through the seven stage tables, checked against a local remap predictor.
// Depends on crrm_pkg and the DUT only.
module chained_range_remap_min_top_tb;

  localparam int          CLK_PERIOD   = 20;
  localparam int          NUM_STAGES   = 7;
  localparam int          ENTRIES      = 64;
  localparam int          STIM_ITEMS   = 950;
  localparam int          PRESS_CYCLES = 3000;
  localparam int          PRESS_AT_A   = 30;
  localparam int          PRESS_AT_B   = 120;
  localparam int          STUCK_LIMIT  = 20000;
  localparam int          DRAIN_CYCLES = 600;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [63:0] ONES         = '1;

  typedef struct {
    logic [1:0]                 func;
    logic [2:0]                 stage;
    logic [5:0]                 index;
    logic                       evld;
    logic [crrm_pkg::VAL_W-1:0] dest;
    logic [crrm_pkg::VAL_W-1:0] src;
    logic [crrm_pkg::VAL_W-1:0] len;
    logic [crrm_pkg::VAL_W-1:0] value;
  } remap_item_t;

  typedef struct {
    logic [crrm_pkg::VAL_W-1:0] mapped;
    logic [crrm_pkg::VAL_W-1:0] minv;
  } xlate_result_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [crrm_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [crrm_pkg::IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [crrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Local copy of the tables and the running minimum.
  logic [crrm_pkg::VAL_W-1:0] tbl_dest [NUM_STAGES*ENTRIES];
  logic [crrm_pkg::VAL_W-1:0] tbl_src  [NUM_STAGES*ENTRIES];
  logic [crrm_pkg::VAL_W-1:0] tbl_len  [NUM_STAGES*ENTRIES];
  logic                       tbl_vld  [NUM_STAGES*ENTRIES];
  logic [crrm_pkg::VAL_W-1:0] run_min;

  remap_item_t   stim_items [$];
  xlate_result_t due_results [$];
  remap_item_t   drv_item;
  xlate_result_t want;

  int          err_count   = 0;
  int          items_in    = 0;
  int          stim_total  = 0;
  int          snd_idle    = 0;
  int          rcv_idle    = 0;
  int          rcv_count   = 0;
  int          rcv_next;
  int          stuck_cnt   = 0;
  logic [31:0] cyc         = '0;
  logic        snd_calm;
  logic        rcv_calm;

  assign snd_calm = (cyc[11:10] == 2'd0);
  assign rcv_calm = (cyc[11:10] == 2'd2);

  chained_range_remap_min_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int idle_len(input logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Every field random, function code included.
  function automatic remap_item_t noise_item();
    remap_item_t it;
    it.func  = 2'($urandom_range(0, 3));
    it.stage = 3'($urandom_range(0, 7));
    it.index = 6'($urandom_range(0, 63));
    it.evld  = 1'($urandom_range(0, 1));
    it.dest  = rand64();
    it.src   = rand64();
    it.len   = rand64();
    it.value = rand64();
    return it;
  endfunction

  function automatic remap_item_t write_item(input logic [2:0] stg, input logic [5:0] idx,
                                             input logic v, input logic [63:0] d,
                                             input logic [63:0] s, input logic [63:0] l);
    remap_item_t it;
    it       = noise_item();
    it.func  = crrm_pkg::FUNC_WRITE;
    it.stage = stg;
    it.index = idx;
    it.evld  = v;
    it.dest  = d;
    it.src   = s;
    it.len   = l;
    return it;
  endfunction

  function automatic remap_item_t xlate_item(input logic [63:0] v);
    remap_item_t it;
    it       = noise_item();
    it.func  = crrm_pkg::FUNC_XLATE;
    it.value = v;
    return it;
  endfunction

  function automatic remap_item_t clear_item();
    remap_item_t it;
    it      = noise_item();
    it.func = crrm_pkg::FUNC_CLEAR;
    return it;
  endfunction

  function automatic logic [crrm_pkg::IN_TDATA_W-1:0] pack_tdata(input remap_item_t it);
    logic [crrm_pkg::IN_TDATA_W-1:0] td;
    td                                        = '0;
    td[crrm_pkg::STG_LSB +: crrm_pkg::STG_W]  = it.stage;
    td[crrm_pkg::IDX_LSB +: crrm_pkg::IDX_W]  = it.index;
    td[crrm_pkg::EVLD_LSB]                    = it.evld;
    td[crrm_pkg::DEST_LSB +: crrm_pkg::VAL_W] = it.dest;
    td[crrm_pkg::SRC_LSB +: crrm_pkg::VAL_W]  = it.src;
    td[crrm_pkg::LEN_LSB +: crrm_pkg::VAL_W]  = it.len;
    td[crrm_pkg::VIN_LSB +: crrm_pkg::VAL_W]  = it.value;
    return td;
  endfunction

  // Walk the value through every stage; the lowest valid index that holds it wins.
  function automatic logic [63:0] remap_chain(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] x_hit;
    logic        hit;
    int          slot;
    x = v;
    for (int s = 0; s < NUM_STAGES; s++) begin
      hit   = 1'b0;
      x_hit = x;
      for (int k = 0; k < ENTRIES; k++) begin
        slot = s * ENTRIES + k;
        if (!hit && tbl_vld[slot] && x >= tbl_src[slot] &&
            (x - tbl_src[slot]) < tbl_len[slot]) begin
          x_hit = tbl_dest[slot] + (x - tbl_src[slot]);
          hit   = 1'b1;
        end
      end
      x = x_hit;
    end
    return x;
  endfunction

  task automatic track_item(input logic [1:0] fn,
                            input logic [crrm_pkg::IN_TDATA_W-1:0] td);
    logic [2:0]    stg;
    logic [5:0]    idx;
    int            slot;
    xlate_result_t res;
    stg = td[crrm_pkg::STG_LSB +: crrm_pkg::STG_W];
    idx = td[crrm_pkg::IDX_LSB +: crrm_pkg::IDX_W];
    case (fn)
      crrm_pkg::FUNC_WRITE: begin
        if (stg < NUM_STAGES && idx < ENTRIES) begin
          slot           = stg * ENTRIES + idx;
          tbl_dest[slot] = td[crrm_pkg::DEST_LSB +: crrm_pkg::VAL_W];
          tbl_src[slot]  = td[crrm_pkg::SRC_LSB +: crrm_pkg::VAL_W];
          tbl_len[slot]  = td[crrm_pkg::LEN_LSB +: crrm_pkg::VAL_W];
          tbl_vld[slot]  = td[crrm_pkg::EVLD_LSB];
        end
      end
      crrm_pkg::FUNC_XLATE: begin
        res.mapped = remap_chain(td[crrm_pkg::VIN_LSB +: crrm_pkg::VAL_W]);
        if (res.mapped < run_min) run_min = res.mapped;
        res.minv = run_min;
        due_results.push_back(res);
      end
      crrm_pkg::FUNC_CLEAR: run_min = ONES;
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] exp_val);
    if (err_count < 50)
      $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, exp_val);
    err_count++;
  endtask

  // Sender: hold the item until taken, then idle a random while before the next.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      snd_idle      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (snd_idle > 0) begin
        s_axis_tvalid <= 1'b0;
        snd_idle      <= snd_idle - 1;
      end else if (stim_items.size() != 0) begin
        drv_item = stim_items.pop_front();
        s_axis_tdata  <= pack_tdata(drv_item);
        s_axis_tuser  <= drv_item.func;
        s_axis_tvalid <= 1'b1;
        snd_idle      <= idle_len(snd_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus two long hold-offs that back the block up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rcv_idle      <= 0;
    end else if (rcv_idle > 0) begin
      m_axis_tready <= 1'b0;
      rcv_idle      <= rcv_idle - 1;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rcv_next = (rcv_count == PRESS_AT_A || rcv_count == PRESS_AT_B) ?
                   PRESS_CYCLES : idle_len(rcv_calm);
        rcv_count <= rcv_count + 1;
      end else if (!m_axis_tready) begin
        rcv_next = 0;
      end else begin
        rcv_next = ($urandom_range(0, 31) == 0) ? idle_len(rcv_calm) : 0;
      end
      m_axis_tready <= (rcv_next == 0);
      rcv_idle      <= (rcv_next == 0) ? 0 : rcv_next - 1;
    end
  end

  // Check results before taking in a new item: a result always belongs to an older one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result", m_axis_tdata[crrm_pkg::VAL_W-1:0], '0);
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[crrm_pkg::VAL_W-1:0] !== want.mapped)
            flag_mismatch("mapped_value", m_axis_tdata[crrm_pkg::VAL_W-1:0], want.mapped);
          if (m_axis_tdata[2*crrm_pkg::VAL_W-1:crrm_pkg::VAL_W] !== want.minv)
            flag_mismatch("min_value", m_axis_tdata[2*crrm_pkg::VAL_W-1:crrm_pkg::VAL_W],
                          want.minv);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_item(s_axis_tuser, s_axis_tdata);
        items_in++;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, STUCK_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  initial begin
    logic [63:0] base;
    logic [63:0] len;
    logic [63:0] src;
    logic [63:0] dest;
    int          r;
    remap_item_t odd_item;

    for (int i = 0; i < NUM_STAGES * ENTRIES; i++) tbl_vld[i] = 1'b0;
    run_min = ONES;

    // Directed: empty tables, min tracking, overlap priority, range edges,
    // zero length, range past the top with wrapping, invalidation, bad targets.
    stim_items.push_back(xlate_item(64'd0));
    stim_items.push_back(xlate_item(ONES));
    stim_items.push_back(clear_item());
    stim_items.push_back(xlate_item(ONES));
    stim_items.push_back(write_item(3'd0, 6'd0, 1'b1, 64'd1000, 64'd100, 64'd10));
    stim_items.push_back(write_item(3'd0, 6'd1, 1'b1, 64'd5000, 64'd100, 64'd20));
    stim_items.push_back(xlate_item(64'd105));
    stim_items.push_back(xlate_item(64'd109));
    stim_items.push_back(xlate_item(64'd110));
    stim_items.push_back(xlate_item(64'd99));
    stim_items.push_back(write_item(3'd1, 6'd63, 1'b1, 64'd7, 64'd1009, 64'd0));
    stim_items.push_back(xlate_item(64'd109));
    stim_items.push_back(write_item(3'd6, 6'd5, 1'b1, ONES, ONES - 64'd9, ONES));
    stim_items.push_back(xlate_item(ONES));
    stim_items.push_back(write_item(3'd0, 6'd0, 1'b0, 64'd1000, 64'd100, 64'd10));
    stim_items.push_back(xlate_item(64'd105));
    stim_items.push_back(write_item(3'd7, 6'd0, 1'b1, 64'd0, 64'd0, ONES));
    stim_items.push_back(xlate_item(64'd42));
    odd_item      = noise_item();
    odd_item.func = FUNC_UNUSED;
    stim_items.push_back(odd_item);
    stim_items.push_back(clear_item());
    stim_items.push_back(write_item(3'd3, 6'd0, 1'b1, 64'h8000_0000_0000_0000, 64'd0, ONES));
    stim_items.push_back(xlate_item(64'd5));
    stim_items.push_back(write_item(3'd3, 6'd0, 1'b0, ONES, ONES, ONES));
    stim_items.push_back(xlate_item(64'd0));

    // Random: bursts of entries packed into a small window, then values from that
    // window so that translations hit and chain across stages.
    while (stim_items.size() < STIM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       base = 64'd0;
        1:       base = 64'h0000_0001_0000_0000;
        2:       base = ONES - 64'd4095;
        default: base = rand64();
      endcase
      repeat ($urandom_range(2, 10)) begin
        r    = $urandom_range(0, 19);
        len  = (r == 0) ? 64'd0 : (r == 1) ? rand64() : 64'($urandom_range(1, 600));
        src  = (r == 2) ? rand64() : base + 64'($urandom_range(0, 4095));
        dest = (r == 3) ? rand64() : base + 64'($urandom_range(0, 4095));
        stim_items.push_back(write_item(($urandom_range(0, 24) == 0) ? 3'd7 :
                                        3'($urandom_range(0, 6)),
                                        6'($urandom_range(0, 63)),
                                        $urandom_range(0, 7) != 0, dest, src, len));
      end
      repeat ($urandom_range(1, 4))
        stim_items.push_back(xlate_item(($urandom_range(0, 9) == 0) ? rand64() :
                                        base + 64'($urandom_range(0, 4095))));
      r = $urandom_range(0, 19);
      if (r == 0) begin
        stim_items.push_back(clear_item());
      end else if (r == 1) begin
        odd_item      = noise_item();
        odd_item.func = FUNC_UNUSED;
        stim_items.push_back(odd_item);
      end else if (r == 2) begin
        stim_items.push_back(noise_item());
      end
    end
    stim_total = stim_items.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_in < stim_total) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
